/* rtl/sbgp_pkg.sv */
// Shared widths for the soft-body gas pressure force block.
package sbgp_pkg;
    localparam int DIVD_W = 72;
    localparam int DIVS_W = 64;
    localparam int SQ_W   = 62;
    localparam int RT_W   = 31;
endpackage

/* rtl/sbgp_div.sv */
// Restoring divider, one quotient bit per cycle.
module sbgp_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sbgp_pkg::DIVD_W-1:0] dividend,
    input  logic [sbgp_pkg::DIVS_W-1:0] divisor,
    output logic [sbgp_pkg::DIVD_W-1:0] quotient,
    output logic                        done
);
    localparam int CNT_W = $clog2(sbgp_pkg::DIVD_W);

    logic [sbgp_pkg::DIVS_W-1:0] rem_reg, rem_next;
    logic [sbgp_pkg::DIVD_W-1:0] quo_reg, quo_next;
    logic [sbgp_pkg::DIVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [sbgp_pkg::DIVS_W:0]   r_sh;
    logic [sbgp_pkg::DIVS_W:0]   r_sub;

    always_comb
    begin
        r_sh      = {rem_reg, quo_reg[sbgp_pkg::DIVD_W-1]};
        r_sub     = r_sh - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(sbgp_pkg::DIVD_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (r_sh >= {1'b0, dvs_reg})
            begin
                rem_next = r_sub[sbgp_pkg::DIVS_W-1:0];
                quo_next = {quo_reg[sbgp_pkg::DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = r_sh[sbgp_pkg::DIVS_W-1:0];
                quo_next = {quo_reg[sbgp_pkg::DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule

/* rtl/sbgp_sqrt.sv */
// Bitwise integer square root, one result bit per cycle.
module sbgp_sqrt
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sbgp_pkg::SQ_W-1:0] radicand,
    output logic [sbgp_pkg::RT_W-1:0] root,
    output logic                      done
);
    localparam int CNT_W = $clog2(sbgp_pkg::RT_W);

    logic [sbgp_pkg::SQ_W-1:0] v_reg, v_next;
    logic [sbgp_pkg::SQ_W-1:0] r_reg, r_next;
    logic [sbgp_pkg::SQ_W-1:0] b_reg, b_next;
    logic [sbgp_pkg::SQ_W-1:0] trial;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    always_comb
    begin
        trial     = r_reg + b_reg;
        v_next    = v_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            v_next    = radicand;
            r_next    = '0;
            b_next    = {2'b01, {(sbgp_pkg::SQ_W-2){1'b0}}};
            cnt_next  = CNT_W'(sbgp_pkg::RT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            b_next   = b_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign root = r_reg[sbgp_pkg::RT_W-1:0];
    assign done = done_reg;
endmodule

/* rtl/soft_body_gas_pressure_force.sv */
// Soft-body gas pressure force: vertex store, sequencer and shared multiplier.
//
// Vertices enter on the vertex channel (valid/ready), one per cycle while
// loading. The item flagged last_vertex closes the polygon; ready then drops
// and the block works through the stored vertices with one shared 33x33
// multiplier, one restoring divider and one square-root unit. An area pass
// over all vertices comes first, then the magnitude multiply and, for a
// nonzero area, the divide; then each vertex in turn gets its offset, norm,
// square root and, where needed, two divides before its force item is shown.
// Each force item waits in the output register until force_ready is high;
// the block holds while the receiver stalls. After the item flagged
// last_force is taken, the block returns to loading. Reset empties the
// vertex store and restores gas_strength to 1.0 and area_scale to 1.
// Configuration writes are taken at any cycle with cfg_we high.
module soft_body_gas_pressure_force
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               vertex_valid,
    output logic               vertex_ready,
    input  logic signed [31:0] vertex_x,
    input  logic signed [31:0] vertex_y,
    input  logic               last_vertex,
    output logic               force_valid,
    input  logic               force_ready,
    output logic signed [31:0] force_x,
    output logic signed [31:0] force_y,
    output logic [5:0]         vertex_number,
    output logic               last_force
);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    localparam logic CFG_GAS   = 1'b0;
    localparam logic CFG_SCALE = 1'b1;

    localparam logic [4:0] S_LOAD  = 5'd0;
    localparam logic [4:0] S_PRD   = 5'd1;
    localparam logic [4:0] S_PLAT  = 5'd2;
    localparam logic [4:0] S_ARD   = 5'd3;
    localparam logic [4:0] S_AMUL  = 5'd4;
    localparam logic [4:0] S_AACC  = 5'd5;
    localparam logic [4:0] S_MULG  = 5'd6;
    localparam logic [4:0] S_DIVM  = 5'd7;
    localparam logic [4:0] S_DIVMW = 5'd8;
    localparam logic [4:0] S_VRD   = 5'd9;
    localparam logic [4:0] S_VMX   = 5'd10;
    localparam logic [4:0] S_VDX   = 5'd11;
    localparam logic [4:0] S_VDY   = 5'd12;
    localparam logic [4:0] S_VNORM = 5'd13;
    localparam logic [4:0] S_VSQX  = 5'd14;
    localparam logic [4:0] S_VSQY  = 5'd15;
    localparam logic [4:0] S_VSQS  = 5'd16;
    localparam logic [4:0] S_VSQRT = 5'd17;
    localparam logic [4:0] S_VSQW  = 5'd18;
    localparam logic [4:0] S_VFX   = 5'd19;
    localparam logic [4:0] S_VDVX  = 5'd20;
    localparam logic [4:0] S_VDXW  = 5'd21;
    localparam logic [4:0] S_VFY   = 5'd22;
    localparam logic [4:0] S_VDVY  = 5'd23;
    localparam logic [4:0] S_VDYW  = 5'd24;
    localparam logic [4:0] S_OUT   = 5'd25;

    logic [31:0] mem_x [MAX_VERTICES];
    logic [31:0] mem_y [MAX_VERTICES];

    logic [4:0]         state_reg, state_next;
    logic [30:0]        gas_reg;
    logic [15:0]        scale_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      n_reg;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] rdx_reg, rdy_reg;
    logic signed [31:0] prevx_reg, prevy_reg;
    logic signed [31:0] cury_reg;
    logic [63:0]        area_reg;
    logic signed [39:0] sumx_reg, sumy_reg;
    logic               sign_reg;
    logic [32:0]        mul_a, mul_b;
    logic [65:0]        mul_p_reg;
    logic [31:0]        mag_reg;
    logic signed [40:0] dx_reg, dy_reg;
    logic [29:0]        ax_reg, ay_reg;
    logic               xneg_reg, yneg_reg;
    logic [60:0]        sqacc_reg;
    logic [sbgp_pkg::SQ_W-1:0] sqv_reg;
    logic [sbgp_pkg::RT_W-1:0] len_reg;
    logic [31:0]        fx_reg, fy_reg;

    logic [CW-1:0]      two_h;
    logic signed [32:0] term_a, term_b;
    logic [63:0]        den;
    logic signed [40:0] pterm;
    logic signed [40:0] dnew;
    logic [40:0]        abx, aby, orv;
    logic [3:0]         shamt;
    logic [40:0]        ax_sh, ay_sh;

    logic                        div_start, div_done;
    logic [sbgp_pkg::DIVD_W-1:0] div_dividend, div_q;
    logic [sbgp_pkg::DIVS_W-1:0] div_divisor;
    logic                        sq_start, sq_done;
    logic [sbgp_pkg::RT_W-1:0]   sq_root;

    function automatic logic [31:0] encode(input logic neg, input logic [31:0] m);
        logic [31:0] r;
        if (neg)
        begin
            r = 32'd0 - m;
        end
        else if (m[31])
        begin
            r = 32'h7FFF_FFFF;
        end
        else
        begin
            r = m;
        end
        return r;
    endfunction

    assign two_h  = {n_reg[CW-1:1], 1'b0};
    assign term_a = 33'(prevx_reg) + 33'(rdx_reg);
    assign term_b = 33'(prevy_reg) - 33'(rdy_reg);
    assign den    = area_reg[63] ? (64'd0 - area_reg) : area_reg;
    assign pterm  = 41'(mul_p_reg[37:0]);
    assign abx    = dx_reg[40] ? 41'(-dx_reg) : 41'(dx_reg);
    assign aby    = dy_reg[40] ? 41'(-dy_reg) : 41'(dy_reg);
    assign orv    = abx | aby;
    assign ax_sh  = abx >> shamt;
    assign ay_sh  = aby >> shamt;

    always_comb
    begin
        shamt = 4'd11;
        for (int s = 11; s >= 0; s--)
        begin
            if ((orv >> s) < 41'h4000_0000)
            begin
                shamt = 4'(s);
            end
        end
    end

    always_comb
    begin
        if (state_reg == S_VDX)
        begin
            dnew = (xneg_reg ? -pterm : pterm) - 41'(sumx_reg);
        end
        else
        begin
            dnew = (yneg_reg ? -pterm : pterm) - 41'(sumy_reg);
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_AMUL:
            begin
                mul_a = term_a[32] ? 33'(-term_a) : 33'(term_a);
                mul_b = term_b[32] ? 33'(-term_b) : 33'(term_b);
            end
            S_MULG:
            begin
                mul_a = {2'b00, gas_reg};
                mul_b = {17'd0, scale_reg};
            end
            S_VMX:
            begin
                mul_a = 33'(two_h);
                mul_b = rdx_reg[31] ? 33'(-33'(rdx_reg)) : 33'(rdx_reg);
            end
            S_VDX:
            begin
                mul_a = 33'(two_h);
                mul_b = cury_reg[31] ? 33'(-33'(cury_reg)) : 33'(cury_reg);
            end
            S_VSQX:
            begin
                mul_a = 33'(ax_reg);
                mul_b = 33'(ax_reg);
            end
            S_VSQY:
            begin
                mul_a = 33'(ay_reg);
                mul_b = 33'(ay_reg);
            end
            S_VFX:
            begin
                mul_a = 33'(mag_reg);
                mul_b = 33'(ax_reg);
            end
            S_VFY:
            begin
                mul_a = 33'(mag_reg);
                mul_b = 33'(ay_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rd_addr = (state_reg == S_PRD) ? AW'(n_reg - 1'b1) : idx_reg[AW-1:0];

    assign div_start    = ((state_reg == S_DIVM) && (den != '0))
                          || (state_reg == S_VDVX) || (state_reg == S_VDVY);
    assign div_dividend = (state_reg == S_DIVM) ? {mul_p_reg[46:0], 25'd0}
                                                : {11'd0, mul_p_reg[60:0]};
    assign div_divisor  = (state_reg == S_DIVM) ? den : 64'(len_reg);
    assign sq_start     = (state_reg == S_VSQRT);

    sbgp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    sbgp_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sqv_reg),
        .root     (sq_root),
        .done     (sq_done)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (vertex_valid)
                begin
                    if (count_reg < CW'(MAX_VERTICES))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (last_vertex)
                    begin
                        state_next = S_PRD;
                    end
                end
            end
            S_PRD:   state_next = S_PLAT;
            S_PLAT:
            begin
                idx_next   = '0;
                state_next = S_ARD;
            end
            S_ARD:   state_next = S_AMUL;
            S_AMUL:  state_next = S_AACC;
            S_AACC:
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg == n_reg - 1'b1) ? S_MULG : S_ARD;
            end
            S_MULG:  state_next = S_DIVM;
            S_DIVM:
            begin
                idx_next   = '0;
                state_next = (den == '0) ? S_VRD : S_DIVMW;
            end
            S_DIVMW: state_next = div_done ? S_VRD : S_DIVMW;
            S_VRD:   state_next = S_VMX;
            S_VMX:   state_next = S_VDX;
            S_VDX:   state_next = S_VDY;
            S_VDY:   state_next = S_VNORM;
            S_VNORM: state_next = S_VSQX;
            S_VSQX:  state_next = S_VSQY;
            S_VSQY:  state_next = S_VSQS;
            S_VSQS:  state_next = S_VSQRT;
            S_VSQRT: state_next = S_VSQW;
            S_VSQW:
            begin
                if (sq_done)
                begin
                    state_next = ((two_h == '0) || (sq_root == '0)) ? S_OUT : S_VFX;
                end
            end
            S_VFX:   state_next = S_VDVX;
            S_VDVX:  state_next = S_VDXW;
            S_VDXW:  state_next = div_done ? S_VFY : S_VDXW;
            S_VFY:   state_next = S_VDVY;
            S_VDVY:  state_next = S_VDYW;
            S_VDYW:  state_next = div_done ? S_OUT : S_VDYW;
            S_OUT:
            begin
                if (force_ready)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == n_reg - 1'b1)
                    begin
                        count_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_VRD;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            idx_reg   <= '0;
            n_reg     <= '0;
            gas_reg   <= 31'd65536;
            scale_reg <= 16'd1;
            area_reg  <= '0;
            sumx_reg  <= '0;
            sumy_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GAS:   gas_reg   <= cfg_data;
                    CFG_SCALE: scale_reg <= cfg_data[15:0];
                    default:   gas_reg   <= gas_reg;
                endcase
            end
            if ((state_reg == S_LOAD) && vertex_valid && last_vertex)
            begin
                n_reg <= count_next;
            end
            if ((state_reg == S_AMUL) && (idx_reg < two_h))
            begin
                sumx_reg <= sumx_reg + 40'(rdx_reg);
                sumy_reg <= sumy_reg + 40'(rdy_reg);
            end
            if (state_reg == S_AACC)
            begin
                if (sign_reg)
                begin
                    area_reg <= area_reg - 64'(mul_p_reg[65:8]);
                end
                else
                begin
                    area_reg <= area_reg + 64'(mul_p_reg[65:8]);
                end
            end
            if ((state_reg == S_OUT) && force_ready && (idx_reg == n_reg - 1'b1))
            begin
                area_reg <= '0;
                sumx_reg <= '0;
                sumy_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_LOAD) && vertex_valid && (count_reg < CW'(MAX_VERTICES)))
        begin
            mem_x[count_reg[AW-1:0]] <= vertex_x;
            mem_y[count_reg[AW-1:0]] <= vertex_y;
        end
        rdx_reg   <= mem_x[rd_addr];
        rdy_reg   <= mem_y[rd_addr];
        mul_p_reg <= mul_a * mul_b;
        case (state_reg)
            S_PLAT:
            begin
                prevx_reg <= rdx_reg;
                prevy_reg <= rdy_reg;
            end
            S_AMUL:
            begin
                sign_reg  <= term_a[32] != term_b[32];
                prevx_reg <= rdx_reg;
                prevy_reg <= rdy_reg;
            end
            S_DIVM:
            begin
                mag_reg <= 32'h8000_0000;
            end
            S_DIVMW:
            begin
                if (div_done)
                begin
                    mag_reg <= (div_q[71:31] != '0) ? 32'h8000_0000 : div_q[31:0];
                end
            end
            S_VMX:
            begin
                xneg_reg <= rdx_reg[31];
                cury_reg <= rdy_reg;
            end
            S_VDX:
            begin
                dx_reg   <= dnew;
                yneg_reg <= cury_reg[31];
            end
            S_VDY:
            begin
                dy_reg <= dnew;
            end
            S_VNORM:
            begin
                ax_reg <= ax_sh[29:0];
                ay_reg <= ay_sh[29:0];
            end
            S_VSQY:
            begin
                sqacc_reg <= mul_p_reg[60:0];
            end
            S_VSQS:
            begin
                sqv_reg <= sbgp_pkg::SQ_W'(sqacc_reg) + sbgp_pkg::SQ_W'(mul_p_reg[60:0]);
            end
            S_VSQW:
            begin
                len_reg <= sq_root;
                fx_reg  <= '0;
                fy_reg  <= '0;
            end
            S_VDXW:
            begin
                if (div_done)
                begin
                    fx_reg <= encode(dx_reg[40], div_q[31:0]);
                end
            end
            S_VDYW:
            begin
                if (div_done)
                begin
                    fy_reg <= encode(dy_reg[40], div_q[31:0]);
                end
            end
            default:
            begin
                sign_reg <= sign_reg;
            end
        endcase
    end

    assign vertex_ready  = (state_reg == S_LOAD);
    assign force_valid   = (state_reg == S_OUT);
    assign force_x       = fx_reg;
    assign force_y       = fy_reg;
    assign vertex_number = 6'(idx_reg);
    assign last_force    = (idx_reg == n_reg - 1'b1);
endmodule

/* rtl/sbgp_checker.sv */
// Port-level checks for the soft-body gas pressure force block.
module sbgp_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               vertex_valid,
    input logic               vertex_ready,
    input logic               last_vertex,
    input logic               force_valid,
    input logic               force_ready,
    input logic signed [31:0] force_x,
    input logic signed [31:0] force_y,
    input logic               last_force
);
    assert property (@(posedge clk) disable iff (!rst_n)
        force_valid && !force_ready |=> force_valid && $stable(force_x) && $stable(force_y))
        else $error("force item dropped or changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(vertex_ready && force_valid))
        else $error("loading while forces pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        force_valid && force_ready && last_force |=> !force_valid && vertex_ready)
        else $error("no return to loading after last force");

    assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && vertex_ready && last_vertex |=> !vertex_ready)
        else $error("still loading after last vertex");
endmodule

bind soft_body_gas_pressure_force sbgp_checker u_sbgp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .vertex_valid (vertex_valid),
    .vertex_ready (vertex_ready),
    .last_vertex  (last_vertex),
    .force_valid  (force_valid),
    .force_ready  (force_ready),
    .force_x      (force_x),
    .force_y      (force_y),
    .last_force   (last_force)
);

/* test/soft_body_gas_pressure_force_tb.sv */
// Testbench for the soft-body gas pressure force block: directed and random polygons, scoreboard check.
module soft_body_gas_pressure_force_tb;

    localparam logic REG_GAS_STRENGTH = 1'b0;
    localparam logic REG_AREA_SCALE   = 1'b1;
    localparam int   STORE_DEPTH      = 64;

    typedef struct {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic [5:0]         num;
        logic               last;
    } force_item_t;

    class pressure_scoreboard;
        logic signed [31:0] px [STORE_DEPTH];
        logic signed [31:0] py [STORE_DEPTH];
        int                 count;
        logic [30:0]        gas;
        logic [15:0]        scale;
        force_item_t        pending_forces [$];
        int                 errors;
        int                 polygons;
        int                 forces_seen;

        function new();
            count = 0;
            gas = 31'd65536;
            scale = 16'd1;
            errors = 0;
            polygons = 0;
            forces_seen = 0;
        endfunction

        function void set_reg(logic idx, logic [30:0] v);
            if (idx == REG_GAS_STRENGTH)
                gas = v;
            else
                scale = v[15:0];
        endfunction

        function logic [63:0] root_floor(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function logic [31:0] encode(bit neg, logic [63:0] m);
            if (!neg && m > 64'h7fff_ffff)
                m = 64'h7fff_ffff;
            return neg ? (32'd0 - m[31:0]) : m[31:0];
        endfunction

        function void close_polygon();
            int          h;
            int          j;
            longint      a;
            longint      b;
            longint      sumx;
            longint      sumy;
            longint      dx;
            longint      dy;
            logic [65:0] ua;
            logic [65:0] ub;
            logic [65:0] t;
            logic [63:0] asum;
            logic [63:0] den;
            logic [63:0] mag;
            logic [63:0] ax;
            logic [63:0] ay;
            logic [63:0] len;
            logic [79:0] q;
            force_item_t f;
            h = count / 2;
            asum = 0;
            for (int i = 0; i < count; i++)
            begin
                j = (i == 0) ? count - 1 : i - 1;
                a = longint'(px[j]) + longint'(px[i]);
                b = longint'(py[j]) - longint'(py[i]);
                ua = (a < 0) ? 66'(-a) : 66'(a);
                ub = (b < 0) ? 66'(-b) : 66'(b);
                t = (ua * ub) >> 8;
                asum = asum + (((a < 0) != (b < 0)) ? (64'd0 - t[63:0]) : t[63:0]);
            end
            den = asum[63] ? (64'd0 - asum) : asum;
            if (den == 0)
                mag = 64'd1 << 31;
            else
            begin
                q = ((80'(gas) * 80'(scale)) << 25) / 80'(den);
                mag = (q >= (80'd1 << 31)) ? (64'd1 << 31) : q[63:0];
            end
            sumx = 0;
            sumy = 0;
            for (int i = 0; i < h; i++)
            begin
                sumx += longint'(px[i]) + longint'(px[i + h]);
                sumy += longint'(py[i]) + longint'(py[i + h]);
            end
            for (int i = 0; i < count; i++)
            begin
                f.fx = 0;
                f.fy = 0;
                if (h > 0)
                begin
                    dx = longint'(2 * h) * longint'(px[i]) - sumx;
                    dy = longint'(2 * h) * longint'(py[i]) - sumy;
                    ax = (dx < 0) ? 64'(-dx) : 64'(dx);
                    ay = (dy < 0) ? 64'(-dy) : 64'(dy);
                    while ((ax | ay) >= (64'd1 << 30))
                    begin
                        ax = ax >> 1;
                        ay = ay >> 1;
                    end
                    len = root_floor(ax * ax + ay * ay);
                    if (len != 0)
                    begin
                        f.fx = encode(dx < 0, mag * ax / len);
                        f.fy = encode(dy < 0, mag * ay / len);
                    end
                end
                f.num = 6'(i);
                f.last = (i == count - 1);
                pending_forces = {pending_forces, f};
            end
            polygons++;
            count = 0;
        endfunction

        function void note_vertex(logic signed [31:0] x, logic signed [31:0] y, logic last);
            if (count < STORE_DEPTH)
            begin
                px[count] = x;
                py[count] = y;
                count++;
            end
            if (last)
                close_polygon();
        endfunction

        function void check_force(force_item_t got);
            force_item_t e;
            forces_seen++;
            if (pending_forces.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected force item: fx=%0d fy=%0d num=%0d last=%0b",
                             got.fx, got.fy, got.num, got.last);
                return;
            end
            e = pending_forces.pop_front();
            if (got.fx !== e.fx || got.fy !== e.fy || got.num !== e.num || got.last !== e.last)
            begin
                errors++;
                if (errors <= 10)
                    $display({"force mismatch: exp fx=%0d fy=%0d num=%0d last=%0b,",
                              " got fx=%0d fy=%0d num=%0d last=%0b"},
                             e.fx, e.fy, e.num, e.last, got.fx, got.fy, got.num, got.last);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [30:0]        cfg_data;
    logic               vertex_valid;
    logic               vertex_ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               last_vertex;
    logic               force_valid;
    logic               force_ready;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic [5:0]         vertex_number;
    logic               last_force;

    pressure_scoreboard sb;
    int                 next_gap;
    bit                 burst;
    int                 long_hold;
    int                 vertices_sent;

    soft_body_gas_pressure_force dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .vertex_valid(vertex_valid),
        .vertex_ready(vertex_ready),
        .vertex_x(vertex_x),
        .vertex_y(vertex_y),
        .last_vertex(last_vertex),
        .force_valid(force_valid),
        .force_ready(force_ready),
        .force_x(force_x),
        .force_y(force_y),
        .vertex_number(vertex_number),
        .last_force(last_force)
    );

    always #2 clk = ~clk;

    initial
    begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y, logic last);
        repeat (next_gap) @(posedge clk);
        vertex_valid <= 1'b1;
        vertex_x <= x;
        vertex_y <= y;
        last_vertex <= last;
        do
            @(posedge clk);
        while (!vertex_ready);
        sb.note_vertex(x, y, last);
        vertices_sent++;
        next_gap = burst ? 0 : $urandom_range(0, 17);
        if (next_gap > 0)
            vertex_valid <= 1'b0;
    endtask

    task automatic drain();
        if (next_gap == 0)
            vertex_valid <= 1'b0;
        next_gap = 1;
        while (sb.pending_forces.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [30:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            2, 3: return 32'($signed($urandom_range(0, 2097152)) - 1048576) << 8;
            default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
        endcase
    endfunction

    task automatic random_polygon(int n);
        burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
            send_vertex(pick_coord(), pick_coord(), i == n - 1);
    endtask

    task automatic random_phase(int items);
        int n;
        int sent;
        sent = 0;
        while (sent < items)
        begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            random_polygon(n);
            sent += n;
            if ($urandom_range(0, 4) == 0)
                drain();
        end
        drain();
    endtask

    always
    begin
        int stall;
        force_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = (long_hold > 0) ? long_hold
                                    : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17));
            long_hold = 0;
            if (stall > 0)
            begin
                force_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            force_ready <= 1'b1;
            do
                @(posedge clk);
            while (!force_valid);
            sb.check_force('{fx: force_x, fy: force_y, num: vertex_number, last: last_force});
        end
    end

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_GAS_STRENGTH;
        cfg_data = '0;
        vertex_valid = 1'b0;
        vertex_x = '0;
        vertex_y = '0;
        last_vertex = 1'b0;
        next_gap = 1;
        burst = 0;
        long_hold = 0;
        vertices_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        send_vertex(32'sh0001_0000, 32'sh0002_0000, 1'b1);
        send_vertex(32'sh0001_0000, 32'sh0001_0000, 1'b0);
        send_vertex(-32'sh0001_0000, -32'sh0001_0000, 1'b1);
        send_vertex(32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
        send_vertex(32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_vertex(32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
        send_vertex(32'sh0001_0000, 32'sh0001_0000, 1'b0);
        send_vertex(-32'sh0001_0000, 32'sh0001_0000, 1'b0);
        send_vertex(-32'sh0001_0000, -32'sh0001_0000, 1'b0);
        send_vertex(32'sh0001_0000, -32'sh0001_0000, 1'b1);
        send_vertex(32'sh0000_0000, 32'sh0000_0000, 1'b0);
        send_vertex(32'sh0002_0000, 32'sh0000_0000, 1'b0);
        send_vertex(32'sh0000_0000, 32'sh0000_0000, 1'b0);
        send_vertex(-32'sh0002_0000, 32'sh0000_0000, 1'b1);
        for (int i = 0; i < 5; i++)
            send_vertex(32'sh0003_0000 * (i % 3), 32'sh0002_0000 * ((i + 1) % 4), i == 4);
        for (int i = 0; i < 3; i++)
            send_vertex(32'sh1234_5678, 32'sh1234_5678, i == 2);
        drain();

        write_reg(REG_GAS_STRENGTH, 31'h7fff_ffff);
        write_reg(REG_AREA_SCALE, 31'd65535);
        random_phase(70);

        write_reg(REG_GAS_STRENGTH, 31'd0);
        write_reg(REG_AREA_SCALE, 31'd1);
        send_vertex(32'sh0001_0000, 32'sh0001_0000, 1'b0);
        send_vertex(32'sh0001_0000, 32'sh0001_0000, 1'b1);
        random_phase(50);

        write_reg(REG_GAS_STRENGTH, 31'($urandom()));
        write_reg(REG_AREA_SCALE, 31'($urandom_range(1, 65535)));
        long_hold = 3000;
        random_polygon(6);
        random_polygon(5);
        random_phase(60);

        write_reg(REG_GAS_STRENGTH, 31'(31'd65536 * $urandom_range(1, 40)));
        write_reg(REG_AREA_SCALE, 31'($urandom_range(1, 16)));
        random_polygon(64);
        drain();
        burst = 0;
        for (int i = 0; i < 66; i++)
            send_vertex(pick_coord(), pick_coord(), i == 65);
        drain();

        write_reg(REG_GAS_STRENGTH, 31'd1);
        write_reg(REG_AREA_SCALE, 31'd1);
        random_phase(50);

        vertex_valid <= 1'b0;
        while (sb.pending_forces.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("covered %0d vertices in %0d polygons, %0d force items checked",
                 vertices_sent, sb.polygons, sb.forces_seen);
        $display("mismatches: %0d", sb.errors);
        if (sb.errors == 0 && sb.pending_forces.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* soft_body_gas_pressure_force.f */
rtl/sbgp_pkg.sv
rtl/sbgp_div.sv
rtl/sbgp_sqrt.sv
rtl/soft_body_gas_pressure_force.sv
rtl/sbgp_checker.sv
test/soft_body_gas_pressure_force_tb.sv
